### rtl/sitda_pkg.sv
// Shared constants and types for the signed integer to decimal text converter.
package sitda_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BcdWidth   = 4;
  localparam int unsigned DigitIdxW  = $clog2(NumDigits);
  localparam int unsigned BitCntW    = $clog2(ValueWidth);
  localparam int unsigned CharWidth  = 8;

  localparam logic [CharWidth-1:0] DigitBase = 8'h30;
  localparam logic [CharWidth-1:0] MinusChar = 8'h2D;
  localparam logic [BcdWidth-1:0]  AdjLimit  = 4'd5;
  localparam logic [BcdWidth-1:0]  AdjAdd    = 4'd3;

  typedef logic [BcdWidth-1:0] bcd_t;

  typedef struct packed {
    logic                       neg;
    logic [NumDigits-1:0][BcdWidth-1:0] digits;
  } conv_res_t;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_SHIFT,
    CONV_DONE
  } conv_state_e;

endpackage

### rtl/sitda_in_if.sv
// Input channel carrying one signed 32-bit value per beat.
interface sitda_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [sitda_pkg::ValueWidth-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

### rtl/sitda_out_if.sv
// Output channel carrying one ASCII character and its end marker per beat.
interface sitda_out_if;
  logic                               valid;
  logic                               ready;
  logic [sitda_pkg::CharWidth-1:0]    text_char;
  logic                               last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

### rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII text converter.
// A value accepted on the input channel is converted by a chain of ten decimal
// digit cells that take one magnitude bit per clock. The converter accepts the
// value, shifts in every magnitude bit and then hands the digits to the output
// buffer, waiting there while the buffer is busy. The input is ready again once
// that handover has happened, while the buffer still sends the previous text, one
// character per beat, with an optional leading '-' and no leading zeros; last_char
// marks the final character.
module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  sitda_in_if.sink    in_i,
  sitda_out_if.source out_o
);

  logic                 res_valid, res_ready;
  sitda_pkg::conv_res_t res;

  sitda_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  sitda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_o       (out_o)
  );

endmodule

### rtl/sitda_bcd_cell.sv
// One decimal digit cell of the shift-add-three conversion chain.
module sitda_bcd_cell (
  input  logic                clk_i,
  input  logic                clr_i,
  input  logic                shift_i,
  input  logic                carry_i,
  output logic                carry_o,
  output sitda_pkg::bcd_t     digit_o
);

  sitda_pkg::bcd_t digit_q, digit_d, adj;

  always_comb begin
    adj = (digit_q >= sitda_pkg::AdjLimit) ? digit_q + sitda_pkg::AdjAdd : digit_q;
    carry_o = adj[sitda_pkg::BcdWidth-1];
    digit_d = digit_q;
    if (clr_i) begin
      digit_d = '0;
    end else if (shift_i) begin
      digit_d = {adj[sitda_pkg::BcdWidth-2:0], carry_i};
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

### rtl/sitda_conv.sv
// Sequencer and digit cell chain that turn the magnitude into decimal digits.
module sitda_conv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sitda_in_if.sink              in_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output sitda_pkg::conv_res_t  res_o
);

  sitda_pkg::conv_state_e                 state_q, state_d;
  logic [sitda_pkg::ValueWidth-1:0]       mag_q, mag_d;
  logic                                   neg_q, neg_d;
  logic [sitda_pkg::BitCntW-1:0]          cnt_q, cnt_d;
  logic                                   clr, shift;
  logic [sitda_pkg::NumDigits-1:0]        carry_in, carry_out;
  sitda_pkg::bcd_t [sitda_pkg::NumDigits-1:0] digits;

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    clr         = 1'b0;
    shift       = 1'b0;
    in_i.ready  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      sitda_pkg::CONV_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          neg_d   = in_i.value[sitda_pkg::ValueWidth-1];
          mag_d   = neg_d ? ('0 - in_i.value) : in_i.value;
          cnt_d   = '0;
          clr     = 1'b1;
          state_d = sitda_pkg::CONV_SHIFT;
        end
      end
      sitda_pkg::CONV_SHIFT: begin
        shift = 1'b1;
        mag_d = {mag_q[sitda_pkg::ValueWidth-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == sitda_pkg::BitCntW'(sitda_pkg::ValueWidth - 1)) begin
          state_d = sitda_pkg::CONV_DONE;
        end
      end
      sitda_pkg::CONV_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = sitda_pkg::CONV_IDLE;
        end
      end
      default: begin
        state_d = sitda_pkg::CONV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sitda_pkg::CONV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
  end

  // Each cell takes the bit that overflows from the cell below it; the lowest cell takes the top magnitude bit.
  assign carry_in = {carry_out[sitda_pkg::NumDigits-2:0], mag_q[sitda_pkg::ValueWidth-1]};

  for (genvar g = 0; g < sitda_pkg::NumDigits; g++) begin : g_cell
    sitda_bcd_cell u_cell (
      .clk_i   (clk_i),
      .clr_i   (clr),
      .shift_i (shift),
      .carry_i (carry_in[g]),
      .carry_o (carry_out[g]),
      .digit_o (digits[g])
    );
  end

  assign res_o.neg    = neg_q;
  assign res_o.digits = digits;

endmodule

### rtl/sitda_emit.sv
// Output buffer that sends the sign and the significant digits one per beat.
module sitda_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_valid_i,
  output logic                  res_ready_o,
  input  sitda_pkg::conv_res_t  res_i,
  sitda_out_if.source           out_o
);

  logic                                    active_q, active_d;
  logic                                    sign_q, sign_d;
  logic [sitda_pkg::DigitIdxW-1:0]         pos_q, pos_d;
  sitda_pkg::bcd_t [sitda_pkg::NumDigits-1:0] buf_q;
  logic [sitda_pkg::DigitIdxW-1:0]         lead;
  logic                                    last, out_fire, load;

  always_comb begin
    lead = '0;
    for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
      if (res_i.digits[i] != '0) begin
        lead = sitda_pkg::DigitIdxW'(i);
      end
    end
  end

  assign last        = !sign_q && (pos_q == '0);
  assign out_fire    = out_o.valid && out_o.ready;
  assign res_ready_o = !active_q || (out_fire && last);
  assign load        = res_valid_i && res_ready_o;

  assign out_o.valid     = active_q;
  assign out_o.last_char = last;
  assign out_o.text_char = sign_q ? sitda_pkg::MinusChar
                                  : sitda_pkg::DigitBase | {4'h0, buf_q[pos_q]};

  always_comb begin
    active_d = active_q;
    sign_d   = sign_q;
    pos_d    = pos_q;
    priority if (load) begin
      active_d = 1'b1;
      sign_d   = res_i.neg;
      pos_d    = lead;
    end else if (out_fire) begin
      if (sign_q) begin
        sign_d = 1'b0;
      end else if (last) begin
        active_d = 1'b0;
      end else begin
        pos_d = pos_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      sign_q   <= 1'b0;
      pos_q    <= '0;
    end else begin
      active_q <= active_d;
      sign_q   <= sign_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= res_i.digits;
    end
  end

endmodule

### dv/tb_signed_int_to_decimal_ascii.sv
// Testbench for the signed integer to decimal ASCII converter with a self-checking monitor.
module tb_signed_int_to_decimal_ascii;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned MaxReports = 10;
  localparam logic [sitda_pkg::ValueWidth-1:0] Radix = 10;

  typedef struct packed {
    logic [sitda_pkg::CharWidth-1:0] text_char;
    logic                            last_char;
  } text_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sitda_in_if  in_ch ();
  sitda_out_if out_ch ();

  signed_int_to_decimal_ascii dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  logic [sitda_pkg::ValueWidth-1:0] pending_values[$];
  text_beat_t            decimal_text_q[$];
  int unsigned           mismatch_cnt = 0;
  int unsigned           cycle_cnt = 0;
  int unsigned           in_gap;
  int unsigned           out_stall;
  int unsigned           out_pick;
  bit                    in_busy;
  bit                    steady_in = 1'b0;
  bit                    steady_out = 1'b0;

  always #2 clk_i = ~clk_i;

  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 40) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Appends the characters that the given word must produce, most significant first.
  function automatic void predict_decimal_text(logic [sitda_pkg::ValueWidth-1:0] word);
    logic [sitda_pkg::ValueWidth-1:0] magnitude;
    logic [sitda_pkg::ValueWidth-1:0] digit;
    logic [sitda_pkg::CharWidth-1:0]  digit_chars[$];
    text_beat_t                       beat;
    magnitude = word[sitda_pkg::ValueWidth-1] ? (~word + 1'b1) : word;
    if (word[sitda_pkg::ValueWidth-1]) begin
      beat.text_char = sitda_pkg::MinusChar;
      beat.last_char = 1'b0;
      decimal_text_q.push_back(beat);
    end
    do begin
      digit = magnitude % Radix;
      digit_chars.push_front(sitda_pkg::DigitBase + digit[sitda_pkg::CharWidth-1:0]);
      magnitude = magnitude / Radix;
    end while (magnitude != 0);
    foreach (digit_chars[i]) begin
      beat.text_char = digit_chars[i];
      beat.last_char = (i == digit_chars.size() - 1);
      decimal_text_q.push_back(beat);
    end
  endfunction

  function automatic void note_mismatch(string msg);
    if (mismatch_cnt < MaxReports) $display("Mismatch: %s", msg);
    mismatch_cnt++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      in_gap      <= 0;
    end else begin
      in_busy = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        predict_decimal_text(in_ch.value);
        in_busy = 1'b0;
        if ($urandom_range(0, 15) == 0) steady_in = ~steady_in;
      end
      if (!in_busy) begin
        if (in_gap != 0) begin
          in_ch.valid <= 1'b0;
          in_gap      <= in_gap - 1;
        end else if (pending_values.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.value <= pending_values.pop_front();
          in_gap      <= pick_gap(steady_in);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      out_pick = 0;
      if (out_ch.valid && out_ch.ready) begin
        if (decimal_text_q.size() == 0) begin
          note_mismatch($sformatf("unexpected beat char=%h last=%b",
                                  out_ch.text_char, out_ch.last_char));
        end else if (out_ch.text_char !== decimal_text_q[0].text_char ||
                     out_ch.last_char !== decimal_text_q[0].last_char) begin
          note_mismatch($sformatf("expected char=%h last=%b, got char=%h last=%b",
                                  decimal_text_q[0].text_char, decimal_text_q[0].last_char,
                                  out_ch.text_char, out_ch.last_char));
          void'(decimal_text_q.pop_front());
        end else begin
          void'(decimal_text_q.pop_front());
        end
        if ($urandom_range(0, 31) == 0) steady_out = ~steady_out;
        out_pick = pick_gap(steady_out);
      end else if (out_stall == 0 && $urandom_range(0, 7) == 0) begin
        out_pick = pick_gap(steady_out);
      end
      if (out_pick != 0) begin
        out_ch.ready <= 1'b0;
        out_stall    <= out_pick - 1;
      end else if (out_stall != 0) begin
        out_ch.ready <= 1'b0;
        out_stall    <= out_stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [sitda_pkg::ValueWidth-1:0] v;
    logic [sitda_pkg::ValueWidth-1:0] p;

    pending_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10,
                       32'd99, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                       32'd1000000000, -32'sd1000000000, 32'd999999999,
                       32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890, -32'sd1234567890,
                       32'd4294967286};

    repeat (90) begin
      case ($urandom_range(0, 3))
        0: v = $urandom();
        1: v = $urandom_range(0, 999);
        2: begin
          p = 1;
          repeat ($urandom_range(0, 9)) p = p * Radix;
          v = p + $urandom_range(0, 2) - 1;
        end
        default: v = $urandom() >> $urandom_range(0, 31);
      endcase
      if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
      pending_values.push_back(v);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_values.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (decimal_text_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
